FILE: src/ird_pkg.sv
// Shared types, constants and the ring address helper for the indexed ring deque.
// Used by the controller, the datapath and the top level.
package ird_pkg;

   localparam int DEPTH      = 16;
   localparam int DATA_WIDTH = 32;
   localparam int PTR_W      = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int KIND_W     = 2;
   localparam int POS_W      = 5;
   localparam int STAT_W     = 2;
   localparam int OCC_W      = 5;
   localparam int CAP_W      = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 5;
   localparam int IDX_W      = (CNT_W > POS_W) ? CNT_W : POS_W;

   localparam logic [CSR_IDX_W-1:0] CSR_CAPACITY     = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_ADDED_HOOK   = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_REMOVED_HOOK = CSR_IDX_W'(2);

   typedef enum logic [KIND_W-1:0] {
      KIND_INSERT = 2'd0,
      KIND_REMOVE = 2'd1,
      KIND_READ   = 2'd2,
      KIND_CLEAR  = 2'd3
   } kind_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      RD_SRC,
      RD_POS,
      RD_LAST
   } rd_sel_type;

   typedef enum logic [2:0] {
      RES_REJECT,
      RES_INSERT,
      RES_REMOVE,
      RES_READ,
      RES_CLR_EACH,
      RES_CLR_NONE
   } res_sel_type;

   typedef struct packed {
      logic        load_item;
      logic        rd_en;
      rd_sel_type  rd_sel;
      logic        wr_shift;
      logic        wr_value;
      logic        save_value;
      logic        shift_setup;
      logic        head_dec;
      logic        head_inc;
      logic        cnt_inc;
      logic        cnt_dec;
      logic        cnt_clear;
      logic        emit;
      res_sel_type res_sel;
   } ird_cmd_type;

   typedef struct packed {
      logic       out_free;
      kind_type   kind;
      status_type status;
      logic       front;
      logic       shift_more;
      logic       hook_clear;
      logic       count_one;
   } ird_stat_type;

   // Physical slot of logical offset off from head, ring of cap slots.
   function automatic logic [PTR_W-1:0] ring_addr(input logic [PTR_W-1:0] head,
                                                  input logic [CNT_W-1:0] off,
                                                  input logic [CNT_W-1:0] cap);
      logic [CNT_W:0] sum;
      sum = (CNT_W+1)'(head) + (CNT_W+1)'(off);
      if (sum >= (CNT_W+1)'(cap)) begin
         sum = sum - (CNT_W+1)'(cap);
      end
      return sum[PTR_W-1:0];
   endfunction

endpackage

FILE: src/ird_ctrl.sv
// Controller state machine of the indexed ring deque.
// Depends on ird_pkg; drives ird_datapath through command and status structs.
module ird_ctrl import ird_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  ird_stat_type stat,
   output ird_cmd_type  cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_RM_SAVE,
      S_SH_RD,
      S_SH_WR,
      S_FINISH,
      S_RD_OUT,
      S_CLR_RD,
      S_CLR_OUT
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = S_CHECK;
            end
         end
         S_CHECK: begin
            // hold until the output slot is free, then dispatch
            if (stat.out_free) begin
               unique case (stat.kind)
                  KIND_CLEAR: begin
                     if (stat.hook_clear) begin
                        state_in = S_CLR_RD;
                     end else begin
                        cmd.cnt_clear = 1'b1;
                        cmd.emit      = 1'b1;
                        cmd.res_sel   = RES_CLR_NONE;
                        state_in      = S_IDLE;
                     end
                  end
                  KIND_INSERT: begin
                     if (stat.status != ST_OK) begin
                        cmd.emit    = 1'b1;
                        cmd.res_sel = RES_REJECT;
                        state_in    = S_IDLE;
                     end else begin
                        cmd.shift_setup = 1'b1;
                        cmd.head_dec    = stat.front;
                        state_in        = S_SH_RD;
                     end
                  end
                  KIND_REMOVE: begin
                     if (stat.status != ST_OK) begin
                        cmd.emit    = 1'b1;
                        cmd.res_sel = RES_REJECT;
                        state_in    = S_IDLE;
                     end else begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RD_POS;
                        state_in   = S_RM_SAVE;
                     end
                  end
                  KIND_READ: begin
                     if (stat.status != ST_OK) begin
                        cmd.emit    = 1'b1;
                        cmd.res_sel = RES_REJECT;
                        state_in    = S_IDLE;
                     end else begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RD_POS;
                        state_in   = S_RD_OUT;
                     end
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_RM_SAVE: begin
            cmd.save_value  = 1'b1;
            cmd.shift_setup = 1'b1;
            state_in        = S_SH_RD;
         end
         S_SH_RD: begin
            if (stat.shift_more) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_SRC;
               state_in   = S_SH_WR;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_SH_WR: begin
            cmd.wr_shift = 1'b1;
            state_in     = S_SH_RD;
         end
         S_FINISH: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               if (stat.kind == KIND_INSERT) begin
                  cmd.wr_value = 1'b1;
                  cmd.cnt_inc  = 1'b1;
                  cmd.res_sel  = RES_INSERT;
               end else begin
                  cmd.head_inc = stat.front;
                  cmd.cnt_dec  = 1'b1;
                  cmd.res_sel  = RES_REMOVE;
               end
               state_in = S_IDLE;
            end
         end
         S_RD_OUT: begin
            if (stat.out_free) begin
               cmd.emit    = 1'b1;
               cmd.res_sel = RES_READ;
               state_in    = S_IDLE;
            end
         end
         S_CLR_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_LAST;
            state_in   = S_CLR_OUT;
         end
         S_CLR_OUT: begin
            if (stat.out_free) begin
               cmd.emit    = 1'b1;
               cmd.cnt_dec = 1'b1;
               cmd.res_sel = RES_CLR_EACH;
               state_in    = stat.count_one ? S_IDLE : S_CLR_RD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: src/ird_datapath.sv
// Datapath of the indexed ring deque: slot memory, head, count, registers,
// item latch, shift walker and the output word register. Depends on ird_pkg.
module ird_datapath import ird_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  ird_cmd_type           cmd,
   output ird_stat_type          stat,
   input  logic [KIND_W-1:0]     req_kind,
   input  logic [POS_W-1:0]      req_position,
   input  logic [DATA_WIDTH-1:0] req_value_in,
   input  logic                  req_quiet,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [STAT_W-1:0]     rsp_status,
   output logic [DATA_WIDTH-1:0] rsp_value_out,
   output logic                  rsp_hook_fire,
   output logic [OCC_W-1:0]      rsp_occupancy,
   output logic                  rsp_last
);

   logic [DATA_WIDTH-1:0] mem [DEPTH];

   logic [CNT_W-1:0]      cap_ff, cap_in;
   logic                  added_hook_ff, added_hook_in;
   logic                  removed_hook_ff, removed_hook_in;
   logic [PTR_W-1:0]      head_ff, head_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   kind_type              kind_ff;
   logic [IDX_W-1:0]      pos_ff;
   logic [DATA_WIDTH-1:0] value_ff;
   logic                  quiet_ff;
   logic [DATA_WIDTH-1:0] rd_data_ff;
   logic [DATA_WIDTH-1:0] saved_ff;
   logic [CNT_W-1:0]      j_ff, j_in;
   logic [CNT_W-1:0]      limit_ff, limit_in;
   logic                  dir_up_ff, dir_up_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff, res_status;
   logic [DATA_WIDTH-1:0] rsp_value_ff, res_value;
   logic                  rsp_hook_ff, res_hook;
   logic [OCC_W-1:0]      rsp_occ_ff;
   logic                  rsp_last_ff, res_last;

   logic [IDX_W-1:0]      count_x;
   logic [CNT_W-1:0]      pos_c;
   logic [CNT_W-1:0]      j_src;
   logic [CNT_W-1:0]      rd_off;
   logic [PTR_W-1:0]      rd_addr;
   logic [PTR_W-1:0]      wr_addr;
   status_type            item_status;
   logic                  front;
   logic                  cap_wr;

   assign count_x = IDX_W'(count_ff);
   assign pos_c   = CNT_W'(pos_ff);
   assign front   = pos_ff < IDX_W'(count_ff >> 1);
   assign cap_wr  = csr_wr_en && (csr_index == CSR_CAPACITY);

   always_comb begin
      unique case (kind_ff)
         KIND_INSERT: begin
            if (pos_ff > count_x) begin
               item_status = ST_RANGE;
            end else if (count_ff >= cap_ff) begin
               item_status = ST_FULL;
            end else begin
               item_status = ST_OK;
            end
         end
         KIND_REMOVE, KIND_READ: begin
            if (count_ff == '0) begin
               item_status = ST_EMPTY;
            end else if (pos_ff >= count_x) begin
               item_status = ST_RANGE;
            end else begin
               item_status = ST_OK;
            end
         end
         default: item_status = ST_OK;
      endcase
   end

   assign stat.out_free   = !rsp_valid_ff || rsp_ready;
   assign stat.kind       = kind_ff;
   assign stat.status     = item_status;
   assign stat.front      = front;
   assign stat.shift_more = (j_ff != limit_ff);
   assign stat.hook_clear = removed_hook_ff && (count_ff != '0);
   assign stat.count_one  = (count_ff == CNT_W'(1));

   // memory addressing
   assign j_src = dir_up_ff ? j_ff + CNT_W'(1) : j_ff - CNT_W'(1);

   always_comb begin
      unique case (cmd.rd_sel)
         RD_SRC:  rd_off = j_src;
         RD_POS:  rd_off = pos_c;
         RD_LAST: rd_off = count_ff - CNT_W'(1);
         default: rd_off = j_src;
      endcase
   end

   assign rd_addr = ring_addr(head_ff, rd_off, cap_ff);
   assign wr_addr = ring_addr(head_ff, cmd.wr_value ? pos_c : j_ff, cap_ff);

   always_ff @(posedge clock) begin
      if (cmd.wr_shift) begin
         mem[wr_addr] <= rd_data_ff;
      end else if (cmd.wr_value) begin
         mem[wr_addr] <= value_ff;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // configuration
   always_comb begin
      cap_in          = cap_ff;
      added_hook_in   = added_hook_ff;
      removed_hook_in = removed_hook_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_CAPACITY: begin
               if (csr_wdata[CAP_W-1:0] == '0) begin
                  cap_in = CNT_W'(1);
               end else if (int'(csr_wdata[CAP_W-1:0]) > DEPTH) begin
                  cap_in = CNT_W'(DEPTH);
               end else begin
                  cap_in = CNT_W'(csr_wdata[CAP_W-1:0]);
               end
            end
            CSR_ADDED_HOOK:   added_hook_in   = csr_wdata[0];
            CSR_REMOVED_HOOK: removed_hook_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   // head and count
   always_comb begin
      head_in = head_ff;
      if (cap_wr) begin
         head_in = '0;
      end else if (cmd.head_dec) begin
         head_in = (head_ff == '0) ? PTR_W'(cap_ff - CNT_W'(1)) : head_ff - PTR_W'(1);
      end else if (cmd.head_inc) begin
         head_in = (CNT_W'(head_ff) + CNT_W'(1) == cap_ff) ? '0 : head_ff + PTR_W'(1);
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cap_wr || cmd.cnt_clear) begin
         count_in = '0;
      end else if (cmd.cnt_inc) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.cnt_dec) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // shift walker: j moves one slot per step toward limit
   always_comb begin
      j_in      = j_ff;
      limit_in  = limit_ff;
      dir_up_in = dir_up_ff;
      if (cmd.shift_setup) begin
         if (kind_ff == KIND_INSERT) begin
            limit_in  = pos_c;
            dir_up_in = front;
            j_in      = front ? '0 : count_ff;
         end else begin
            j_in      = pos_c;
            dir_up_in = !front;
            limit_in  = front ? '0 : count_ff - CNT_W'(1);
         end
      end else if (cmd.wr_shift) begin
         j_in = j_src;
      end
   end

   // result selection
   always_comb begin
      res_status = ST_OK;
      res_value  = '0;
      res_hook   = 1'b0;
      res_last   = 1'b1;
      unique case (cmd.res_sel)
         RES_REJECT: res_status = item_status;
         RES_INSERT: begin
            res_value = value_ff;
            res_hook  = added_hook_ff;
         end
         RES_REMOVE: begin
            res_value = saved_ff;
            res_hook  = removed_hook_ff && !quiet_ff;
         end
         RES_READ: res_value = rd_data_ff;
         RES_CLR_EACH: begin
            res_value = rd_data_ff;
            res_hook  = 1'b1;
            res_last  = (count_in == '0);
         end
         RES_CLR_NONE: ;
         default: ;
      endcase
   end

   assign rsp_valid_in = cmd.emit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff          <= CNT_W'(DEPTH);
         added_hook_ff   <= 1'b0;
         removed_hook_ff <= 1'b0;
         head_ff         <= '0;
         count_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         cap_ff          <= cap_in;
         added_hook_ff   <= added_hook_in;
         removed_hook_ff <= removed_hook_in;
         head_ff         <= head_in;
         count_ff        <= count_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      j_ff      <= j_in;
      limit_ff  <= limit_in;
      dir_up_ff <= dir_up_in;
      if (cmd.load_item) begin
         kind_ff  <= kind_type'(req_kind);
         pos_ff   <= IDX_W'(req_position);
         value_ff <= req_value_in;
         quiet_ff <= req_quiet;
      end
      if (cmd.save_value) begin
         saved_ff <= rd_data_ff;
      end
      if (cmd.emit) begin
         rsp_status_ff <= res_status;
         rsp_value_ff  <= res_value;
         rsp_hook_ff   <= res_hook;
         rsp_occ_ff    <= OCC_W'(count_in);
         rsp_last_ff   <= res_last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_value_out = rsp_value_ff;
   assign rsp_hook_fire = rsp_hook_ff;
   assign rsp_occupancy = rsp_occ_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

FILE: src/indexed_ring_deque_core.sv
// Top level of the indexed ring deque: controller plus datapath.
// Depends on ird_pkg, ird_ctrl and ird_datapath.

// Indexed ring deque of 32-bit values in a 16-slot circular store with a head
// pointer and an element count. Each request word inserts at, removes at or
// reads at a logical position counted from the front, or clears the deque;
// inserts and removes move the shorter side (the front side when the position
// is below half the count). Requests are taken one at a time: req_ready is
// high only while the controller is idle. The slot store has one port used
// either for a read or a write in a cycle, and every moved element is read and
// then written back, so the cost of a request is set by that port. An insert
// or remove moves at most about half the count; a clear of a non-empty deque
// with the removed hook enabled emits one response word per element, last
// element first, with rsp_last on the final one. Waiting for rsp_ready to free
// the output register stalls the controller. A finished response word sits in
// an output register, so the next request is accepted while it waits for
// rsp_ready. Registers: index 0 sets the ring size (0 acts as 1, above 16 acts
// as 16) and empties the deque; index 1 enables the added hook; index 2 enables
// the removed hook. Write registers only while idle.
module indexed_ring_deque_core import ird_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [KIND_W-1:0]     req_kind,
   input  logic [POS_W-1:0]      req_position,
   input  logic [DATA_WIDTH-1:0] req_value_in,
   input  logic                  req_quiet,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [STAT_W-1:0]     rsp_status,
   output logic [DATA_WIDTH-1:0] rsp_value_out,
   output logic                  rsp_hook_fire,
   output logic [OCC_W-1:0]      rsp_occupancy,
   output logic                  rsp_last,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   ird_cmd_type  cmd;
   ird_stat_type stat;

   // sequencing: accept, check, shift loop, emit
   ird_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // storage, pointers, configuration and the response register
   ird_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_kind      (req_kind),
      .req_position  (req_position),
      .req_value_in  (req_value_in),
      .req_quiet     (req_quiet),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_value_out (rsp_value_out),
      .rsp_hook_fire (rsp_hook_fire),
      .rsp_occupancy (rsp_occupancy),
      .rsp_last      (rsp_last)
   );

`ifndef ASSERT_OFF
   // never overwrite a response word that has not been taken
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> stat.out_free)
      else $error("response emitted over a pending word");

   // single memory port: one write per cycle, never with a read
   a_one_port: assert property (@(posedge clock) disable iff (reset)
      !(cmd.wr_shift && cmd.wr_value) && !(cmd.rd_en && (cmd.wr_shift || cmd.wr_value)))
      else $error("slot memory port used twice in a cycle");

   // a request is worked on alone: no new accept right after one
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while previous one in progress");

   // only a hooked clear produces non-final responses
   a_multi_clear: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> (rsp_hook_fire && rsp_status == ST_OK))
      else $error("non-final response outside a hooked clear");
`endif

endmodule

FILE: tb/indexed_ring_deque_core_tb.sv
// Self-checking testbench for indexed_ring_deque_core: directed and random request words,
// checked word by word against a behavioral deque kept inside the bench.
// Depends on ird_pkg and the indexed_ring_deque_core RTL.
module indexed_ring_deque_core_tb;
   import ird_pkg::*;

   // Expected response word, one per result the deque produces
   typedef struct packed {
      status_type            status;
      logic [DATA_WIDTH-1:0] value;
      logic                  hook;
      logic [OCC_W-1:0]      occ;
      logic                  last;
   } deque_rsp_type;

   localparam int SETTLE_CYCLES = 40;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [KIND_W-1:0]     req_kind;
   logic [POS_W-1:0]      req_position;
   logic [DATA_WIDTH-1:0] req_value_in;
   logic                  req_quiet;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [STAT_W-1:0]     rsp_status;
   logic [DATA_WIDTH-1:0] rsp_value_out;
   logic                  rsp_hook_fire;
   logic [OCC_W-1:0]      rsp_occupancy;
   logic                  rsp_last;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // Bench copy of the deque state and its registers
   logic [DATA_WIDTH-1:0] m_slot [DEPTH];
   int                    m_head;
   int                    m_count;
   int                    m_cap_raw;
   logic                  m_added_on;
   logic                  m_removed_on;

   deque_rsp_type rsp_due_q[$];
   int            mismatch_count;
   bit            no_gaps;

   indexed_ring_deque_core u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_kind      (req_kind),
      .req_position  (req_position),
      .req_value_in  (req_value_in),
      .req_quiet     (req_quiet),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_value_out (rsp_value_out),
      .rsp_hook_fire (rsp_hook_fire),
      .rsp_occupancy (rsp_occupancy),
      .rsp_last      (rsp_last),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Hard stop in case the block hangs
   initial begin
      #8000000;
      $display("FAIL indexed_ring_deque_core");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // Behavioral deque
   // ---------------------------------------------------------------------------

   // Ring size in effect: 0 acts as 1, anything above DEPTH acts as DEPTH
   function automatic int ring_size();
      if (m_cap_raw == 0) return 1;
      if (m_cap_raw > DEPTH) return DEPTH;
      return m_cap_raw;
   endfunction

   function automatic void push_due(status_type st, logic [DATA_WIDTH-1:0] val, logic hook,
                                    int occ, logic last);
      deque_rsp_type w;
      w.status = st;
      w.value  = val;
      w.hook   = hook;
      w.occ    = OCC_W'(occ);
      w.last   = last;
      rsp_due_q.push_back(w);
   endfunction

   // Apply one accepted request word and queue the response words it causes
   function automatic void deque_step(kind_type kind, int pos, logic [DATA_WIDTH-1:0] val,
                                      logic quiet);
      int                    cap;
      int                    base;
      int                    j;
      logic [DATA_WIDTH-1:0] taken;
      cap = ring_size();
      pos = pos & 31;
      case (kind)
         KIND_INSERT: begin
            if (pos > m_count) begin
               push_due(ST_RANGE, '0, 1'b0, m_count, 1'b1);
            end else if (m_count >= cap) begin
               push_due(ST_FULL, '0, 1'b0, m_count, 1'b1);
            end else begin
               if (pos < m_count / 2) begin
                  // front side moves one slot toward the new head
                  base = (m_head + cap - 1) % cap;
                  for (j = 0; j < pos; j++) begin
                     m_slot[(base + j) % cap] = m_slot[(base + j + 1) % cap];
                  end
                  m_head = base;
               end else begin
                  for (j = m_count; j > pos; j--) begin
                     m_slot[(m_head + j) % cap] = m_slot[(m_head + j - 1) % cap];
                  end
               end
               m_slot[(m_head + pos) % cap] = val;
               m_count++;
               push_due(ST_OK, val, m_added_on, m_count, 1'b1);
            end
         end
         KIND_REMOVE: begin
            if (m_count == 0) begin
               push_due(ST_EMPTY, '0, 1'b0, 0, 1'b1);
            end else if (pos >= m_count) begin
               push_due(ST_RANGE, '0, 1'b0, m_count, 1'b1);
            end else begin
               taken = m_slot[(m_head + pos) % cap];
               if (pos < m_count / 2) begin
                  for (j = pos; j > 0; j--) begin
                     m_slot[(m_head + j) % cap] = m_slot[(m_head + j - 1) % cap];
                  end
                  m_head = (m_head + 1) % cap;
               end else begin
                  for (j = pos; j + 1 < m_count; j++) begin
                     m_slot[(m_head + j) % cap] = m_slot[(m_head + j + 1) % cap];
                  end
               end
               m_count--;
               push_due(ST_OK, taken, m_removed_on & ~quiet, m_count, 1'b1);
            end
         end
         KIND_READ: begin
            if (m_count == 0) begin
               push_due(ST_EMPTY, '0, 1'b0, 0, 1'b1);
            end else if (pos >= m_count) begin
               push_due(ST_RANGE, '0, 1'b0, m_count, 1'b1);
            end else begin
               push_due(ST_OK, m_slot[(m_head + pos) % cap], 1'b0, m_count, 1'b1);
            end
         end
         default: begin
            // clear: with the removed hook on, hand back every element last to first
            if (m_removed_on && m_count > 0) begin
               while (m_count > 0) begin
                  taken = m_slot[(m_head + m_count - 1) % cap];
                  m_count--;
                  push_due(ST_OK, taken, 1'b1, m_count, m_count == 0);
               end
            end else begin
               m_count = 0;
               push_due(ST_OK, '0, 1'b0, 0, 1'b1);
            end
         end
      endcase
   endfunction

   // ---------------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------------

   // Mostly short gaps, now and then a long one
   function automatic int gap_len();
      int r;
      r = $urandom_range(99);
      if (no_gaps || r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Send one request word; hold valid and payload until accepted. Valid is left
   // high so a back-to-back word needs no second assignment in the same step.
   task automatic send_word(input kind_type kind, input int pos,
                            input logic [DATA_WIDTH-1:0] val, input logic quiet);
      int gap;
      gap = gap_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_kind     <= kind;
      req_position <= POS_W'(pos);
      req_value_in <= val;
      req_quiet    <= quiet;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      deque_step(kind, pos, val, quiet);
   endtask

   // Drop valid and wait until every expected word has come and the block is idle
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (rsp_due_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Call only while idle; lowers the enable again before returning so it never toggles twice a step
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(data);
      @(posedge clock);
      case (idx)
         CSR_CAPACITY: begin
            m_cap_raw = data & 31;
            m_head    = 0;
            m_count   = 0;
         end
         CSR_ADDED_HOOK:   m_added_on   = data[0];
         CSR_REMOVED_HOOK: m_removed_on = data[0];
         default: ;
      endcase
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_mode(input int cap, input bit added, input bit removed);
      wait_idle();
      write_reg(CSR_CAPACITY, cap);
      write_reg(CSR_ADDED_HOOK, int'(added));
      write_reg(CSR_REMOVED_HOOK, int'(removed));
   endtask

   // Receiver: bursts of ready, short stalls, occasional long stall
   initial begin
      int burst;
      int stall;
      rsp_ready <= 1'b1;
      forever begin
         burst = ($urandom_range(3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
         repeat (burst) @(posedge clock);
         stall = ($urandom_range(99) < 8) ? $urandom_range(20, 60) : $urandom_range(0, 3);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
            rsp_ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Response checker
   // ---------------------------------------------------------------------------

   task automatic note_mismatch(input string what, input deque_rsp_type exp_w,
                                input deque_rsp_type got_w);
      if (mismatch_count < 10) begin
         $display("%s: expected st=%0d val=%h hook=%b occ=%0d last=%b,", what,
                  exp_w.status, exp_w.value, exp_w.hook, exp_w.occ, exp_w.last);
         $display("   got st=%0d val=%h hook=%b occ=%0d last=%b",
                  got_w.status, got_w.value, got_w.hook, got_w.occ, got_w.last);
      end
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      deque_rsp_type got_w;
      deque_rsp_type exp_w;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         got_w.status = status_type'(rsp_status);
         got_w.value  = rsp_value_out;
         got_w.hook   = rsp_hook_fire;
         got_w.occ    = rsp_occupancy;
         got_w.last   = rsp_last;
         if (rsp_due_q.size() == 0) begin
            note_mismatch("unexpected response word", '0, got_w);
         end else begin
            exp_w = rsp_due_q.pop_front();
            if (got_w !== exp_w) note_mismatch("response mismatch", exp_w, got_w);
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // Reads, removes and clears on an empty deque; insert past the end
   task automatic test_empty_deque();
      send_word(KIND_READ, 0, 32'h1, 1'b0);
      send_word(KIND_REMOVE, 0, 32'h2, 1'b0);
      send_word(KIND_CLEAR, 0, 32'h3, 1'b0);
      send_word(KIND_INSERT, 1, 32'h4, 1'b0);
   endtask

   // Inserts that move the front side (head wraps below slot 0) and the back side, then reads
   task automatic test_insert_and_read();
      send_word(KIND_INSERT, 0, 32'h0000_0000, 1'b0);
      send_word(KIND_INSERT, 1, 32'hFFFF_FFFF, 1'b1);
      send_word(KIND_INSERT, 0, 32'hA5A5_5A5A, 1'b0);
      send_word(KIND_INSERT, 3, 32'h1234_5678, 1'b0);
      send_word(KIND_INSERT, 2, 32'h8000_0001, 1'b0);
      send_word(KIND_INSERT, 1, 32'h0F0F_F0F0, 1'b0);
      send_word(KIND_READ, 0, 32'h0, 1'b0);
      send_word(KIND_READ, 5, 32'h0, 1'b0);
      send_word(KIND_READ, 6, 32'h0, 1'b0);
   endtask

   // Removes from both sides, a remove past the end, and a silent clear
   task automatic test_remove_sides();
      send_word(KIND_REMOVE, 1, 32'h0, 1'b0);
      send_word(KIND_REMOVE, 3, 32'h0, 1'b1);
      send_word(KIND_REMOVE, 9, 32'h0, 1'b0);
      send_word(KIND_CLEAR, 0, 32'h0, 1'b0);
   endtask

   // Small ring with both hooks: full store, range before full, steal, emitting clear
   task automatic test_hooks_and_full();
      set_mode(3, 1'b1, 1'b1);
      send_word(KIND_INSERT, 0, 32'hDEAD_0001, 1'b0);
      send_word(KIND_INSERT, 1, 32'hDEAD_0002, 1'b0);
      send_word(KIND_INSERT, 1, 32'hDEAD_0003, 1'b0);
      send_word(KIND_INSERT, 0, 32'hDEAD_0004, 1'b0);
      send_word(KIND_INSERT, 31, 32'hDEAD_0005, 1'b0);
      send_word(KIND_REMOVE, 0, 32'h0, 1'b1);
      send_word(KIND_CLEAR, 0, 32'h0, 1'b0);
   endtask

   // Capacity 0 acts as a single slot
   task automatic test_capacity_clamp();
      set_mode(0, 1'b0, 1'b1);
      send_word(KIND_INSERT, 0, 32'h7777_7777, 1'b0);
      send_word(KIND_INSERT, 0, 32'h6666_6666, 1'b0);
      send_word(KIND_REMOVE, 0, 32'h0, 1'b0);
   endtask

   // Random mix: insert-heavy first half to reach full, remove-heavy second half
   task automatic run_mix(input int n);
      int                    i;
      int                    r;
      int                    ins_pct;
      int                    pos;
      kind_type              kind;
      logic [DATA_WIDTH-1:0] val;
      for (i = 0; i < n; i++) begin
         ins_pct = (i < n / 2) ? 62 : 28;
         r = $urandom_range(99);
         if (r < ins_pct) kind = KIND_INSERT;
         else if (r < ins_pct + (95 - ins_pct) / 2) kind = KIND_REMOVE;
         else if (r < 95) kind = KIND_READ;
         else kind = KIND_CLEAR;
         if ($urandom_range(9) == 0) pos = $urandom_range(31);
         else if (kind == KIND_INSERT) pos = $urandom_range(m_count);
         else pos = (m_count == 0) ? 0 : $urandom_range(m_count - 1);
         r = $urandom_range(9);
         val = (r == 0) ? '0 : (r == 1) ? '1 : $urandom;
         send_word(kind, pos, val, 1'($urandom_range(1)));
      end
   endtask

   // Several register settings, extremes among them
   task automatic test_random_phases();
      int caps   [7] = '{16, 1, 5, 0, 31, 9, 16};
      int counts [7] = '{35, 15, 26, 12, 35, 30, 30};
      int p;
      for (p = 0; p < 7; p++) begin
         if (p == 5) set_mode($urandom_range(2, 15), 1'($urandom_range(1)),
                              1'($urandom_range(1)));
         else set_mode(caps[p], p % 2 == 0, p != 4);
         // no sender gaps for the clamped-high ring
         no_gaps = (p == 4);
         if (p == 2) begin
            // pause mid-phase until every response word is back
            run_mix(counts[p] / 2);
            wait_idle();
            run_mix(counts[p] - counts[p] / 2);
         end else begin
            run_mix(counts[p]);
         end
      end
      no_gaps = 1'b0;
   endtask

   initial begin
      mismatch_count = 0;
      no_gaps        = 1'b0;
      foreach (m_slot[i]) m_slot[i] = '0;
      m_head       = 0;
      m_count      = 0;
      m_cap_raw    = DEPTH;
      m_added_on   = 1'b0;
      m_removed_on = 1'b0;
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_kind     <= KIND_READ;
      req_position <= '0;
      req_value_in <= '0;
      req_quiet    <= 1'b0;
      csr_wr_en    <= 1'b0;
      csr_index    <= CSR_CAPACITY;
      csr_wdata    <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_deque();
      test_insert_and_read();
      test_remove_sides();
      test_hooks_and_full();
      test_capacity_clamp();
      test_random_phases();

      wait_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && rsp_due_q.size() == 0) begin
         $display("PASS indexed_ring_deque_core");
      end else begin
         $display("FAIL indexed_ring_deque_core");
      end
      $finish;
   end

endmodule
